// ----- rtl/core/ard_pkg.sv -----
// Shared widths, types, codes and helpers for the archive record deframer.
package ard_pkg;

  localparam int RECORD_INDEX_BITS = 16;

  typedef logic [7:0]                   byte_t;
  typedef logic [2:0]                   role_t;
  typedef logic [15:0]                  recnum_t;
  typedef logic [63:0]                  len_t;
  typedef logic [RECORD_INDEX_BITS-1:0] rec_t;

  localparam role_t ROLE_PATH_LEN    = 3'd0;
  localparam role_t ROLE_PATH        = 3'd1;
  localparam role_t ROLE_CONTENT_LEN = 3'd2;
  localparam role_t ROLE_CONTENT     = 3'd3;
  localparam role_t ROLE_PAD         = 3'd4;

  localparam recnum_t RECNUM_MAX = 16'hFFFF;
  localparam rec_t    REC_MAX    = '1;

  // Clamp the internal record counter to the 16-bit label field.
  function automatic recnum_t sat_recnum(input rec_t c);
    if (c > rec_t'(RECNUM_MAX)) begin
      return RECNUM_MAX;
    end
    return recnum_t'(c);
  endfunction

endpackage

// ----- rtl/core/ard_if.sv -----
// Stream interfaces for the byte input, the label output and the marker write.
interface ard_in_if import ard_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  start_of_block;

  modport source (output valid, output data_byte, output start_of_block, input ready);
  modport sink   (input valid, input data_byte, input start_of_block, output ready);
endinterface

interface ard_out_if import ard_pkg::*; ();
  logic    valid;
  logic    ready;
  role_t   byte_role;
  recnum_t record_number;
  len_t    byte_position;
  len_t    field_total;
  logic    value_valid;
  len_t    field_value;
  logic    is_terminator;
  logic    is_dir_marker;

  modport source (output valid, output byte_role, output record_number,
                  output byte_position, output field_total, output value_valid,
                  output field_value, output is_terminator, output is_dir_marker,
                  input ready);
  modport sink   (input valid, input byte_role, input record_number,
                  input byte_position, input field_total, input value_valid,
                  input field_value, input is_terminator, input is_dir_marker,
                  output ready);
endinterface

interface ard_cfg_if import ard_pkg::*; ();
  logic valid;
  logic ready;
  len_t dir_marker;

  modport source (output valid, output dir_marker, input ready);
  modport sink   (input valid, input dir_marker, output ready);
endinterface

// ----- rtl/core/archive_record_deframer_unit.sv -----
// Archive record deframer: labels each payload byte with its record field.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------
//  rx      | in  | data_byte, start_of_block                 | valid/ready
//  tx      | out | byte_role .. is_dir_marker (one label)    | valid/ready
//  cfg     | in  | dir_marker                                | valid/ready
//
// One byte per cycle sustained while tx accepts; a byte accepted on rx
// waits in the input register, and its label is offered on tx from the
// label register. Parser state updates as a byte moves into the label
// register. rst is synchronous and restores the parser and sets
// dir_marker to all ones. A stalled tx holds the label; rx takes one more
// byte into the input register and then holds ready low until tx accepts.
module archive_record_deframer_unit import ard_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ard_in_if.sink        rx,
  ard_out_if.source     tx,
  ard_cfg_if.sink       cfg
);

  localparam logic [2:0] STAGE_PATH_LEN    = 3'd0;
  localparam logic [2:0] STAGE_PATH        = 3'd1;
  localparam logic [2:0] STAGE_CONTENT_LEN = 3'd2;
  localparam logic [2:0] STAGE_CONTENT     = 3'd3;
  localparam logic [2:0] STAGE_PAD         = 3'd4;

  // configuration
  len_t dir_marker;

  // input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_start;

  // parser state
  logic [2:0]  stage, stage_next;
  rec_t        record_count, record_count_next;
  logic [3:0]  len_seen, len_seen_next;
  len_t        len_shift, len_shift_next;
  logic [15:0] path_length, path_length_next;
  logic [15:0] path_seen, path_seen_next;
  len_t        content_length, content_length_next;
  len_t        content_seen, content_seen_next;

  // label register
  logic    out_valid;
  role_t   role_next;
  recnum_t recnum_next;
  len_t    pos_next;
  len_t    total_next;
  logic    vval_next;
  len_t    val_next;
  logic    term_next;
  logic    dir_next;

  logic advance;

  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;
  assign tx.valid = out_valid;

  always_comb begin
    logic [2:0]  st_cur;
    rec_t        cnt_cur;
    rec_t        cnt_bump;
    logic [3:0]  lseen_cur;
    logic [3:0]  lseen_inc;
    len_t        lshift_cur;
    len_t        shift_or;
    logic [15:0] plen_cur;
    logic [15:0] pseen_inc;
    len_t        clen_cur;
    len_t        cseen_inc;
    logic        dir_hit;

    // start_of_block clears the parser before this byte
    st_cur     = in_start ? STAGE_PATH_LEN : stage;
    cnt_cur    = in_start ? '0 : record_count;
    lseen_cur  = in_start ? '0 : len_seen;
    lshift_cur = in_start ? '0 : len_shift;
    plen_cur   = in_start ? '0 : path_length;
    clen_cur   = in_start ? '0 : content_length;

    lseen_inc = lseen_cur + 4'd1;
    pseen_inc = (in_start ? 16'd0 : path_seen) + 16'd1;
    cseen_inc = (in_start ? 64'd0 : content_seen) + 64'd1;
    cnt_bump  = (cnt_cur == REC_MAX) ? cnt_cur : cnt_cur + rec_t'(1);

    // merge the byte into its little-endian lane
    shift_or = lshift_cur;
    for (int i = 0; i < 8; i++) begin
      if (lseen_cur[2:0] == 3'(i)) begin
        shift_or[8*i +: 8] = lshift_cur[8*i +: 8] | in_byte;
      end
    end
    dir_hit = (shift_or == dir_marker);

    stage_next          = st_cur;
    record_count_next   = cnt_cur;
    len_seen_next       = lseen_cur;
    len_shift_next      = lshift_cur;
    path_length_next    = plen_cur;
    path_seen_next      = in_start ? 16'd0 : path_seen;
    content_length_next = clen_cur;
    content_seen_next   = in_start ? 64'd0 : content_seen;

    role_next   = ROLE_PAD;
    recnum_next = sat_recnum(cnt_cur);
    pos_next    = '0;
    total_next  = '0;
    vval_next   = 1'b0;
    val_next    = '0;
    term_next   = 1'b0;
    dir_next    = 1'b0;

    case (st_cur)
      STAGE_PATH_LEN: begin
        len_seen_next  = lseen_inc;
        len_shift_next = shift_or;
        role_next      = ROLE_PATH_LEN;
        pos_next       = 64'(lseen_inc);
        total_next     = 64'd2;
        if (lseen_inc >= 4'd2) begin
          path_length_next = shift_or[15:0];
          vval_next        = 1'b1;
          val_next         = 64'(shift_or[15:0]);
          len_seen_next    = '0;
          len_shift_next   = '0;
          if (shift_or[15:0] == 16'd0) begin
            term_next  = 1'b1;
            stage_next = STAGE_PAD;
          end else begin
            path_seen_next = '0;
            stage_next     = STAGE_PATH;
          end
        end
      end
      STAGE_PATH: begin
        path_seen_next = pseen_inc;
        role_next      = ROLE_PATH;
        pos_next       = 64'(pseen_inc);
        total_next     = (plen_cur == 16'd0) ? 64'd1 : 64'(plen_cur);
        if (pseen_inc >= plen_cur) begin
          len_seen_next  = '0;
          len_shift_next = '0;
          stage_next     = STAGE_CONTENT_LEN;
        end
      end
      STAGE_CONTENT_LEN: begin
        len_seen_next  = lseen_inc;
        len_shift_next = shift_or;
        role_next      = ROLE_CONTENT_LEN;
        pos_next       = 64'(lseen_inc);
        total_next     = 64'd8;
        if (lseen_inc >= 4'd8) begin
          content_length_next = shift_or;
          vval_next           = 1'b1;
          val_next            = shift_or;
          len_seen_next       = '0;
          len_shift_next      = '0;
          dir_next            = dir_hit;
          // directory or empty file: the record ends here
          if (dir_hit || shift_or == 64'd0) begin
            record_count_next = cnt_bump;
            stage_next        = STAGE_PATH_LEN;
          end else begin
            content_seen_next = '0;
            stage_next        = STAGE_CONTENT;
          end
        end
      end
      STAGE_CONTENT: begin
        content_seen_next = cseen_inc;
        role_next         = ROLE_CONTENT;
        pos_next          = cseen_inc;
        total_next        = clen_cur;
        if (cseen_inc >= clen_cur) begin
          record_count_next = cnt_bump;
          stage_next        = STAGE_PATH_LEN;
        end
      end
      default: begin
        recnum_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_marker <= '1;
    end else if (cfg.valid && cfg.ready) begin
      dir_marker <= cfg.dir_marker;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte  <= rx.data_byte;
      in_start <= rx.start_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= STAGE_PATH_LEN;
      record_count   <= '0;
      len_seen       <= '0;
      len_shift      <= '0;
      path_length    <= '0;
      path_seen      <= '0;
      content_length <= '0;
      content_seen   <= '0;
    end else if (advance) begin
      stage          <= stage_next;
      record_count   <= record_count_next;
      len_seen       <= len_seen_next;
      len_shift      <= len_shift_next;
      path_length    <= path_length_next;
      path_seen      <= path_seen_next;
      content_length <= content_length_next;
      content_seen   <= content_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx.byte_role     <= role_next;
      tx.record_number <= recnum_next;
      tx.byte_position <= pos_next;
      tx.field_total   <= total_next;
      tx.value_valid   <= vval_next;
      tx.field_value   <= val_next;
      tx.is_terminator <= term_next;
      tx.is_dir_marker <= dir_next;
    end
  end

  // padding labels carry no record, position or size
  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.byte_role == ROLE_PAD |->
      tx.record_number == '0 && tx.byte_position == '0 && tx.field_total == '0)
    else $error("padding label with nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.value_valid |-> tx.field_value == '0 && !tx.is_terminator
      && !tx.is_dir_marker)
    else $error("length value or flag without a completed length field");

  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.is_terminator |-> tx.byte_role == ROLE_PATH_LEN
      && tx.field_value == '0)
    else $error("terminator flag outside a zero path length");

  assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.is_dir_marker |-> tx.byte_role == ROLE_CONTENT_LEN
      && tx.byte_position == 64'd8)
    else $error("directory flag outside the last content length byte");

endmodule
